>>> rtl/core/sstk_pkg.sv
// ----------------------------------------------------------------------------
// sstk_pkg
// Shared types and constants of the sample sequence freshness tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sstk_pkg;

  // Field widths
  localparam int unsigned SEQ_BITS      = 16;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned THR_BITS      = 31;
  localparam int unsigned SRC_BITS      = 16;
  localparam int unsigned CODE_BITS     = 3;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = THR_BITS;

  // Highest legal telemetry kind and quality codes, and the fault quality code
  localparam logic [CODE_BITS-1:0] MAX_TELEM_KIND = 3'd4;
  localparam logic [CODE_BITS-1:0] MAX_QUALITY    = 3'd3;
  localparam logic [CODE_BITS-1:0] QUALITY_FAULT  = 3'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_BAD_ARG  = 2'd2,
    ST_BAD_CFG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SQ_FIRST     = 3'd0,
    SQ_IN_ORDER  = 3'd1,
    SQ_GAP       = 3'd2,
    SQ_DUPLICATE = 3'd3,
    SQ_REORDERED = 3'd4
  } seq_class_e;

  typedef enum logic [1:0] {
    FR_FRESH = 2'd0,
    FR_AGING = 2'd1,
    FR_STALE = 2'd2
  } fresh_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_SOURCE = 2'd1,
    CFG_AGING  = 2'd2,
    CFG_STALE  = 2'd3
  } cfg_idx_e;

  // Input item
  typedef struct packed {
    item_kind_e            kind;
    logic [TIME_BITS-1:0]  time_now;
    logic [SRC_BITS-1:0]   sample_source;
    logic [SEQ_BITS-1:0]   sample_sequence;
    logic [CODE_BITS-1:0]  telemetry_kind;
    logic [CODE_BITS-1:0]  sample_quality;
    logic [VALUE_BITS-1:0] sample_value;
  } in_t;

  // Result item
  typedef struct packed {
    status_e               status;
    seq_class_e            sequence_state;
    fresh_e                freshness;
    logic [TIME_BITS-1:0]  age;
    logic [SEQ_BITS-1:0]   held_sequence;
    logic [CODE_BITS-1:0]  held_kind;
    logic [CODE_BITS-1:0]  held_quality;
    logic [VALUE_BITS-1:0] held_value;
    logic                  has_sample;
  } out_t;

  // Configuration registers
  typedef struct packed {
    logic                enable;
    logic [SRC_BITS-1:0] source_id;
    logic [THR_BITS-1:0] aging_after;
    logic [THR_BITS-1:0] stale_after;
  } cfg_t;

  // Tracker state
  typedef struct packed {
    logic                  sample_held;
    logic [SEQ_BITS-1:0]   last_sequence;
    logic [CODE_BITS-1:0]  stored_kind;
    logic [CODE_BITS-1:0]  stored_quality;
    logic [VALUE_BITS-1:0] stored_payload;
    logic [TIME_BITS-1:0]  receive_time;
    seq_class_e            seq_class;
    fresh_e                fresh_class;
    logic [TIME_BITS-1:0]  current_age;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    enable:      1'b0,
    source_id:   '0,
    aging_after: '0,
    stale_after: THR_BITS'(1)
  };

  localparam state_t STATE_RESET = '{
    sample_held:    1'b0,
    last_sequence:  '0,
    stored_kind:    '0,
    stored_quality: QUALITY_FAULT,
    stored_payload: '0,
    receive_time:   '0,
    seq_class:      SQ_FIRST,
    fresh_class:    FR_STALE,
    current_age:    '0
  };

endpackage

`default_nettype wire

>>> rtl/core/sstk_cfg_regs.sv
// ----------------------------------------------------------------------------
// sstk_cfg_regs
// Configuration register file: decodes the write port into the four fields.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sstk_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [sstk_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output sstk_pkg::cfg_t                           cfg_o
);

  sstk_pkg::cfg_t cfg_q, cfg_d;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sstk_pkg::cfg_idx_e'(cfg_idx_i))
        sstk_pkg::CFG_ENABLE: cfg_d.enable      = cfg_data_i[0];
        sstk_pkg::CFG_SOURCE: cfg_d.source_id   = cfg_data_i[sstk_pkg::SRC_BITS-1:0];
        sstk_pkg::CFG_AGING:  cfg_d.aging_after = cfg_data_i[sstk_pkg::THR_BITS-1:0];
        sstk_pkg::CFG_STALE:  cfg_d.stale_after = cfg_data_i[sstk_pkg::THR_BITS-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sstk_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/sstk_update.sv
// ----------------------------------------------------------------------------
// sstk_update
// Next-state and status logic for one item: sequence classification of a
// sample, age and freshness grading of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_update (
  input  wire sstk_pkg::cfg_t   cfg_i,
  input  wire sstk_pkg::state_t state_i,
  input  wire sstk_pkg::in_t    item_i,
  output sstk_pkg::state_t      state_o,
  output sstk_pkg::status_e     status_o
);

  logic [sstk_pkg::SEQ_BITS-1:0]  seq_diff;
  logic [sstk_pkg::TIME_BITS-1:0] age_now;
  logic                           bad_cfg;
  logic                           bad_arg;
  logic [sstk_pkg::TIME_BITS-1:0] aging_ext;
  logic [sstk_pkg::TIME_BITS-1:0] stale_ext;

  // Modular differences against the held sample
  assign seq_diff  = item_i.sample_sequence - state_i.last_sequence;
  assign age_now   = item_i.time_now - state_i.receive_time;
  assign aging_ext = sstk_pkg::TIME_BITS'(cfg_i.aging_after);
  assign stale_ext = sstk_pkg::TIME_BITS'(cfg_i.stale_after);

  assign bad_cfg = (cfg_i.aging_after >= cfg_i.stale_after) ||
                   (cfg_i.stale_after == '0);
  assign bad_arg = (item_i.sample_source != cfg_i.source_id) ||
                   (item_i.telemetry_kind > sstk_pkg::MAX_TELEM_KIND) ||
                   (item_i.sample_quality > sstk_pkg::MAX_QUALITY);

  always_comb begin
    state_o  = state_i;
    status_o = sstk_pkg::ST_OK;
    if (!cfg_i.enable) begin
      status_o = sstk_pkg::ST_NOT_INIT;
    end else if (bad_cfg) begin
      status_o = sstk_pkg::ST_BAD_CFG;
    end else if (item_i.kind == sstk_pkg::KIND_SAMPLE) begin
      if (bad_arg) begin
        status_o = sstk_pkg::ST_BAD_ARG;
      end else if (state_i.sample_held && (seq_diff == '0)) begin
        state_o.seq_class = sstk_pkg::SQ_DUPLICATE;
      end else if (state_i.sample_held && seq_diff[sstk_pkg::SEQ_BITS-1]) begin
        // behind by up to half the range: rejected
        state_o.seq_class = sstk_pkg::SQ_REORDERED;
      end else begin
        // first, in-order or gap sample replaces the held one
        state_o.sample_held    = 1'b1;
        state_o.last_sequence  = item_i.sample_sequence;
        state_o.stored_kind    = item_i.telemetry_kind;
        state_o.stored_quality = item_i.sample_quality;
        state_o.stored_payload = item_i.sample_value;
        state_o.receive_time   = item_i.time_now;
        state_o.fresh_class    = sstk_pkg::FR_FRESH;
        state_o.current_age    = '0;
        if (!state_i.sample_held) begin
          state_o.seq_class = sstk_pkg::SQ_FIRST;
        end else if (seq_diff == sstk_pkg::SEQ_BITS'(1)) begin
          state_o.seq_class = sstk_pkg::SQ_IN_ORDER;
        end else begin
          state_o.seq_class = sstk_pkg::SQ_GAP;
        end
      end
    end else if (state_i.sample_held) begin
      // tick: grade the age of the held sample
      state_o.current_age = age_now;
      if (age_now >= stale_ext) begin
        state_o.fresh_class = sstk_pkg::FR_STALE;
      end else if (age_now >= aging_ext) begin
        state_o.fresh_class = sstk_pkg::FR_AGING;
      end else begin
        state_o.fresh_class = sstk_pkg::FR_FRESH;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sample_sequence_freshness_tracker_core.sv
// ----------------------------------------------------------------------------
// sample_sequence_freshness_tracker_core
// Tracks the freshness and sequence order of a telemetry sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries either a
//   sample or a time tick. Each item yields exactly one result on the output
//   channel (out_valid_o / out_stall_i / out_data_o) showing the status and
//   the tracker state after that item.
//   The item is registered in the input register, then the state update and
//   the result register are loaded from it. One item per cycle is sustained
//   while no result stalls; the only loop is the update of the state registers.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   in_stall_o is raised in the same cycle.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; every write clears the tracker state.
//   Reset clears the pipe, sets the registers to disabled with thresholds
//   0 and 1, and puts the tracker in its no-sample state.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_sequence_freshness_tracker_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire sstk_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output sstk_pkg::out_t                           out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [sstk_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [sstk_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  sstk_pkg::cfg_t    cfg;
  sstk_pkg::state_t  state_q, state_d, state_next;
  sstk_pkg::status_e status;
  sstk_pkg::in_t     item_q;
  sstk_pkg::out_t    res_q, res_d;
  logic              item_valid_q;
  logic              res_valid_q;
  logic              advance;

  sstk_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sstk_update u_update (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_next),
    .status_o (status)
  );

  // Pipe moves unless a waiting result is stalled
  assign advance    = !(res_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (advance) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      item_q <= in_data_i;
    end
  end

  // State update; a config write clears the tracker
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = sstk_pkg::STATE_RESET;
    end else if (advance && item_valid_q) begin
      state_d = state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstk_pkg::STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result formatting
  always_comb begin
    res_d.status         = status;
    res_d.sequence_state = state_next.seq_class;
    res_d.freshness      = state_next.fresh_class;
    res_d.age            = state_next.current_age;
    res_d.held_sequence  = state_next.last_sequence;
    res_d.held_kind      = state_next.stored_kind;
    res_d.held_quality   = state_next.stored_quality;
    res_d.held_value     = state_next.stored_payload;
    res_d.has_sample     = state_next.sample_held;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/core/sstk_checker.sv
// ----------------------------------------------------------------------------
// sstk_checker
// Port-level checks of the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_stall_o,
  input  wire logic           out_valid_o,
  input  wire logic           out_stall_i,
  input  wire sstk_pkg::out_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input is held back only by a stalled result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Disabled block never holds a sample
  a_not_init_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == sstk_pkg::ST_NOT_INIT)
      |-> !out_data_o.has_sample)
    else $error("sample held while not initialized");

  // Without a sample the tracker shows its cleared state
  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_sample
      |-> (out_data_o.sequence_state == sstk_pkg::SQ_FIRST) &&
          (out_data_o.freshness == sstk_pkg::FR_STALE) &&
          (out_data_o.age == '0))
    else $error("empty tracker shows non-reset state");

endmodule

bind sample_sequence_freshness_tracker_core sstk_checker u_sstk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> test/sample_sequence_freshness_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// sample_sequence_freshness_tracker_core_tb
// Self-checking bench for the freshness tracker core. Each input transfer is
// run through a behavioral tracker kept inside the bench, and each result
// transfer is compared field by field with the oldest predicted result.
// A directed part hits the corner cases, then random phases with changing
// register settings and random backpressure on both channels follow.
// ----------------------------------------------------------------------------

module sample_sequence_freshness_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sstk_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 40;

  // Behavioral tracker plus the queue of results it predicts
  class tracker_outcome_book;
    cfg_t        regs;
    state_t      trk;
    out_t        pending_results[$];
    int unsigned mismatches;
    int unsigned compared;
    int unsigned status_seen[4];
    int unsigned class_seen[5];

    function new();
      regs       = CFG_RESET;
      trk        = STATE_RESET;
      mismatches = 0;
      compared   = 0;
    endfunction

    // Any register write clears the tracker
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ENABLE: regs.enable      = data[0];
        CFG_SOURCE: regs.source_id   = data[SRC_BITS-1:0];
        CFG_AGING:  regs.aging_after = data;
        CFG_STALE:  regs.stale_after = data;
        default: ;
      endcase
      trk = STATE_RESET;
    endfunction

    // Take the sample as the held one; it is fresh with age zero
    function void hold_sample(in_t item, seq_class_e cls);
      trk.last_sequence  = item.sample_sequence;
      trk.stored_kind    = item.telemetry_kind;
      trk.stored_quality = item.sample_quality;
      trk.stored_payload = item.sample_value;
      trk.receive_time   = item.time_now;
      trk.seq_class      = cls;
      trk.fresh_class    = FR_FRESH;
      trk.current_age    = '0;
      trk.sample_held    = 1'b1;
    endfunction

    function out_t advance_tracker(in_t item);
      status_e             st;
      logic [SEQ_BITS-1:0] seq_delta;
      out_t                res;
      st = ST_OK;
      if (!regs.enable) begin
        st = ST_NOT_INIT;
      end else if (regs.aging_after >= regs.stale_after || regs.stale_after == '0) begin
        st = ST_BAD_CFG;
      end else if (item.kind == KIND_SAMPLE) begin
        if (item.sample_source != regs.source_id || item.telemetry_kind > MAX_TELEM_KIND ||
            item.sample_quality > MAX_QUALITY) begin
          st = ST_BAD_ARG;
        end else if (!trk.sample_held) begin
          hold_sample(item, SQ_FIRST);
        end else begin
          // modular distance from the held sequence number
          seq_delta = item.sample_sequence - trk.last_sequence;
          if (seq_delta == '0) begin
            trk.seq_class = SQ_DUPLICATE;
          end else if (seq_delta[SEQ_BITS-1]) begin
            trk.seq_class = SQ_REORDERED;
          end else begin
            hold_sample(item, (seq_delta == SEQ_BITS'(1)) ? SQ_IN_ORDER : SQ_GAP);
          end
        end
      end else if (trk.sample_held) begin
        // tick: wrapping age, then grade against the thresholds
        trk.current_age = item.time_now - trk.receive_time;
        if (trk.current_age >= TIME_BITS'(regs.stale_after)) begin
          trk.fresh_class = FR_STALE;
        end else if (trk.current_age >= TIME_BITS'(regs.aging_after)) begin
          trk.fresh_class = FR_AGING;
        end else begin
          trk.fresh_class = FR_FRESH;
        end
      end
      res.status         = st;
      res.sequence_state = trk.seq_class;
      res.freshness      = trk.fresh_class;
      res.age            = trk.current_age;
      res.held_sequence  = trk.last_sequence;
      res.held_kind      = trk.stored_kind;
      res.held_quality   = trk.stored_quality;
      res.held_value     = trk.stored_payload;
      res.has_sample     = trk.sample_held;
      return res;
    endfunction

    function void log_transfer(in_t item);
      pending_results.push_back(advance_tracker(item));
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing predicted: actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compared++;
      status_seen[want.status]++;
      class_seen[want.sequence_state]++;
      cmp_field("status", want.status, got.status);
      cmp_field("sequence_state", want.sequence_state, got.sequence_state);
      cmp_field("freshness", want.freshness, got.freshness);
      cmp_field("age", want.age, got.age);
      cmp_field("held_sequence", want.held_sequence, got.held_sequence);
      cmp_field("held_kind", want.held_kind, got.held_kind);
      cmp_field("held_quality", want.held_quality, got.held_quality);
      cmp_field("held_value", want.held_value, got.held_value);
      cmp_field("has_sample", want.has_sample, got.has_sample);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_t                      in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_t                     out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int unsigned cycles       = 0;
  int unsigned items_sent   = 0;
  int unsigned reg_writes   = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  tracker_outcome_book book = new();

  sample_sequence_freshness_tracker_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result monitor: one transfer per edge with valid high and stall low
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      book.match_result(out_data);
    end
  end

  // Receiver backpressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic program_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    book.write_reg(idx, data);
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(logic en, logic [SRC_BITS-1:0] src,
                             logic [THR_BITS-1:0] aging, logic [THR_BITS-1:0] stale);
    program_reg(CFG_ENABLE, CFG_DATA_BITS'(en));
    program_reg(CFG_SOURCE, CFG_DATA_BITS'(src));
    program_reg(CFG_AGING, aging);
    program_reg(CFG_STALE, stale);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One input transfer, with an optional idle burst ahead of it
  task automatic send_item(in_t item);
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    book.log_transfer(item);
    items_sent++;
  endtask

  function automatic in_t mk(item_kind_e kind, logic [TIME_BITS-1:0] now,
                             logic [SRC_BITS-1:0] src, logic [SEQ_BITS-1:0] seq,
                             logic [CODE_BITS-1:0] tk, logic [CODE_BITS-1:0] q,
                             logic [VALUE_BITS-1:0] val);
    in_t item;
    item.kind            = kind;
    item.time_now        = now;
    item.sample_source   = src;
    item.sample_sequence = seq;
    item.telemetry_kind  = tk;
    item.sample_quality  = q;
    item.sample_value    = val;
    return item;
  endfunction

  // Mostly well-formed items steered around the held sequence and the
  // thresholds; noise items are fully random
  function automatic in_t make_item(bit noisy);
    in_t                  item;
    logic [127:0]         raw;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] aging;
    logic [TIME_BITS-1:0] stale;
    logic [SEQ_BITS-1:0]  last;
    raw  = {$urandom, $urandom, $urandom, $urandom};
    item = raw[$bits(in_t)-1:0];
    if (noisy) return item;
    base  = book.trk.receive_time;
    aging = TIME_BITS'(book.regs.aging_after);
    stale = TIME_BITS'(book.regs.stale_after);
    last  = book.trk.last_sequence;
    item.sample_source  = book.regs.source_id;
    item.telemetry_kind = CODE_BITS'($urandom_range(0, MAX_TELEM_KIND));
    item.sample_quality = CODE_BITS'($urandom_range(0, MAX_QUALITY));
    case ($urandom_range(0, 7))
      0:       item.sample_sequence = last;
      1, 2, 3: item.sample_sequence = last + SEQ_BITS'(1);
      4:       item.sample_sequence = last + SEQ_BITS'($urandom_range(2, 40));
      5:       item.sample_sequence = last + SEQ_BITS'($urandom_range(16'h7ff0, 16'h7fff));
      6:       item.sample_sequence = last + SEQ_BITS'($urandom_range(16'h8000, 16'hffff));
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0:       item.time_now = base + aging - 1;
      1:       item.time_now = base + aging;
      2:       item.time_now = base + stale - 1;
      3:       item.time_now = base + stale;
      4, 5:    item.time_now = base + TIME_BITS'($urandom_range(0, stale + 20));
      default: ;
    endcase
    return item;
  endfunction

  initial begin
    int unsigned         ph;
    logic                en_v;
    logic [SRC_BITS-1:0] src_v;
    logic [THR_BITS-1:0] aging_v;
    logic [THR_BITS-1:0] stale_v;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 10;
    stall_pct    = 10;

    // Block still disabled after reset
    send_item(mk(KIND_SAMPLE, 32'd5, 16'h0000, 16'd1, 3'd0, 3'd0, 32'h1234_5678));
    send_item(mk(KIND_TICK, 32'd9, 16'h0000, 16'd0, 3'd0, 3'd0, 32'h0));
    settle();

    program_all(1'b1, 16'hffff, 31'd3, 31'd10);
    // Tick with nothing held, then rejected samples
    send_item(mk(KIND_TICK, 32'd5, 16'hffff, 16'd0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_SAMPLE, 32'd1, 16'h7fff, 16'd1, 3'd0, 3'd0, 32'h1));
    send_item(mk(KIND_SAMPLE, 32'd1, 16'hffff, 16'd1, 3'd5, 3'd0, 32'h1));
    send_item(mk(KIND_SAMPLE, 32'd1, 16'hffff, 16'd1, 3'd7, 3'd0, 32'h1));
    send_item(mk(KIND_SAMPLE, 32'd1, 16'hffff, 16'd1, 3'd0, 3'd4, 32'h1));
    send_item(mk(KIND_SAMPLE, 32'd1, 16'hffff, 16'd1, 3'd0, 3'd7, 32'h1));
    // First, duplicate, in order across the wrap, reordered, widest gap
    send_item(mk(KIND_SAMPLE, 32'hffff_fff8, 16'hffff, 16'hfffe, 3'd4, 3'd3, 32'hffff_ffff));
    send_item(mk(KIND_SAMPLE, 32'h0, 16'hffff, 16'hfffe, 3'd1, 3'd0, 32'h0));
    send_item(mk(KIND_SAMPLE, 32'hffff_fffa, 16'hffff, 16'hffff, 3'd2, 3'd1, 32'hdead_beef));
    send_item(mk(KIND_SAMPLE, 32'hffff_fffc, 16'hffff, 16'h0000, 3'd3, 3'd2, 32'h0bad_cafe));
    send_item(mk(KIND_SAMPLE, 32'h5, 16'hffff, 16'h8000, 3'd0, 3'd0, 32'h5555_5555));
    send_item(mk(KIND_SAMPLE, 32'hffff_fffe, 16'hffff, 16'h7fff, 3'd0, 3'd3, 32'haaaa_aaaa));
    // Ages across both thresholds, time wrapping past zero
    send_item(mk(KIND_TICK, 32'd0, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_TICK, 32'd1, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_TICK, 32'd7, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_TICK, 32'd8, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_TICK, 32'hffff_fffe, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_SAMPLE, 32'd0, 16'hffff, 16'h8000, 3'd0, 3'd0, 32'h0));
    settle();

    // Thresholds equal, then both zero
    program_reg(CFG_STALE, 31'd3);
    send_item(mk(KIND_SAMPLE, 32'd1, 16'hffff, 16'd1, 3'd0, 3'd0, 32'h1));
    send_item(mk(KIND_TICK, 32'd9, 16'hffff, 16'd1, 3'd0, 3'd0, 32'h1));
    settle();
    program_reg(CFG_AGING, 31'd0);
    program_reg(CFG_STALE, 31'd0);
    send_item(mk(KIND_TICK, 32'd9, 16'hffff, 16'd1, 3'd0, 3'd0, 32'h1));
    settle();

    // Largest thresholds, source id zero
    program_all(1'b1, 16'h0000, 31'h7fff_fffe, 31'h7fff_ffff);
    send_item(mk(KIND_SAMPLE, 32'd0, 16'h0000, 16'd0, 3'd2, 3'd1, 32'h8000_0001));
    send_item(mk(KIND_TICK, 32'h7fff_fffe, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    send_item(mk(KIND_TICK, 32'hffff_ffff, 16'h0, 16'h0, 3'd0, 3'd0, 32'h0));
    settle();

    // Random phases, each with its own register setting and pressure
    for (ph = 0; ph < PHASES; ph++) begin
      en_v    = 1'b1;
      src_v   = SRC_BITS'($urandom_range(0, 16'hffff));
      aging_v = THR_BITS'($urandom_range(0, 300));
      stale_v = aging_v + THR_BITS'($urandom_range(1, 500));
      case (ph)
        2: aging_v = '0;
        4: en_v = 1'b0;
        6: begin
          aging_v = 31'h7fff_fffe;
          stale_v = 31'h7fff_ffff;
        end
        7: stale_v = THR_BITS'($urandom_range(0, aging_v));
        default: ;
      endcase
      // last phases run without any idling
      if (ph >= PHASES - 2) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end else begin
        send_gap_pct = $urandom_range(0, 2) * 15;
        stall_pct    = $urandom_range(0, 2) * 15;
      end
      program_all(en_v, src_v, aging_v, stale_v);
      repeat (PHASE_ITEMS) send_item(make_item($urandom_range(0, 4) == 0));
      settle();
    end

    $display("Covered %0d item transfers and %0d register writes, directed and random.",
             items_sent, reg_writes);
    $display("Compared %0d results: dup %0d, reord %0d, gap %0d, bad arg %0d, bad cfg %0d.",
             book.compared, book.class_seen[SQ_DUPLICATE], book.class_seen[SQ_REORDERED],
             book.class_seen[SQ_GAP], book.status_seen[ST_BAD_ARG],
             book.status_seen[ST_BAD_CFG]);
    if (book.mismatches == 0 && book.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
